/* sv/stable_max_priority_queue_core_macros.svh */
// Assertion macros shared by the priority queue RTL.
`ifndef STABLE_MAX_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_MAX_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds on every rising clock edge outside reset.
`define SMPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a consequent in the cycle that follows its antecedent.
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SMPQ_ASSERT(label, clk, rst_n, prop, msg)
`define SMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/smpq_pkg.sv */
// Types and codes shared by the priority queue cell chain and its top level.
`timescale 1ns / 1ps

package smpq_pkg;

    // Transaction kinds on the input channel
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    // Status that a cell hands to its right-hand neighbour
    typedef struct packed {
        logic valid;
        logic keep;
    } cell_stat_t;

endpackage

/* sv/stable_max_priority_queue_core.sv */
// Top level of the stable max-priority queue built from a chain of sorting cells.
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  s_      | s_valid s_ready s_kind s_entry_data s_priority_req | in
//  m_      | m_valid m_ready m_front_data m_was_empty           | out
//          | m_was_full m_occupancy                             |
//
// One transaction is taken per cycle while s_ready is high; its result appears in the output register
// on the next cycle. The cell chain keeps entries sorted by priority, highest and
// oldest at cell zero, so each insert or remove is one parallel shift of the chain.
// Synchronous active-low reset clears the cell valid bits, the count and m_valid.
// s_ready drops only while a result waits in the output register and m_ready is low.
`timescale 1ns / 1ps
`include "stable_max_priority_queue_core_macros.svh"

module stable_max_priority_queue_core
    import smpq_pkg::*;
#(
    parameter int CAPACITY      = 16,
    parameter int DATA_BITS     = 32,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic [DATA_BITS-1:0]                 s_entry_data,
    input  logic [PRIORITY_BITS-1:0]             s_priority_req,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [DATA_BITS-1:0]                 m_front_data,
    output logic                                 m_was_empty,
    output logic                                 m_was_full,
    output logic [$clog2(CAPACITY+1)-1:0]        m_occupancy
);

    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam logic [COUNT_BITS-1:0] CAP_COUNT = COUNT_BITS'(CAPACITY);

    logic                     s_acc;
    logic                     is_full, is_empty;
    cell_op_t                 op;
    logic [COUNT_BITS-1:0]    count_reg, count_next;

    cell_stat_t               cell_stat [CAPACITY];
    logic [DATA_BITS-1:0]     cell_data [CAPACITY];
    logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
    logic [CAPACITY-1:0]      valid_vec;

    logic                     m_valid_reg, m_valid_next;
    logic [DATA_BITS-1:0]     front_reg, front_next;
    logic                     empty_reg, empty_next;
    logic                     full_reg, full_next;
    logic [COUNT_BITS-1:0]    occ_reg, occ_next;

    // Accept whenever the output register is free or being drained
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_acc    = s_valid && s_ready;
    assign is_full  = (count_reg == CAP_COUNT);
    assign is_empty = (count_reg == '0);

    // Decode the transaction into the chain operation and the result
    always_comb begin
        op           = OP_HOLD;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        front_next   = front_reg;
        empty_next   = empty_reg;
        full_next    = full_reg;
        occ_next     = occ_reg;
        if (s_acc) begin
            m_valid_next = 1'b1;
            front_next   = '0;
            empty_next   = 1'b0;
            full_next    = 1'b0;
            if (s_kind == KIND_INSERT) begin
                if (is_full) begin
                    full_next = 1'b1;
                end else begin
                    op         = OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end else begin
                if (is_empty) begin
                    empty_next = 1'b1;
                end else begin
                    op         = OP_REMOVE;
                    front_next = cell_data[0];
                    count_next = count_reg - 1'b1;
                end
            end
            occ_next = count_next;
        end
    end

    // Build the chain with fixed ends
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        cell_stat_t               l_stat;
        logic [DATA_BITS-1:0]     l_data, r_data;
        logic [PRIORITY_BITS-1:0] l_prio, r_prio;
        logic                     r_valid;

        if (i == 0) begin : g_head
            assign l_stat = '{valid: 1'b0, keep: 1'b1};
            assign l_data = '0;
            assign l_prio = '0;
        end else begin : g_mid
            assign l_stat = cell_stat[i-1];
            assign l_data = cell_data[i-1];
            assign l_prio = cell_prio[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_data  = '0;
            assign r_prio  = '0;
        end else begin : g_body
            assign r_valid = cell_stat[i+1].valid;
            assign r_data  = cell_data[i+1];
            assign r_prio  = cell_prio[i+1];
        end

        smpq_cell #(
            .DATA_BITS     (DATA_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .op          (op),
            .ins_data    (s_entry_data),
            .ins_prio    (s_priority_req),
            .left_stat   (l_stat),
            .left_data   (l_data),
            .left_prio   (l_prio),
            .right_valid (r_valid),
            .right_data  (r_data),
            .right_prio  (r_prio),
            .stat        (cell_stat[i]),
            .data        (cell_data[i]),
            .prio        (cell_prio[i])
        );

        assign valid_vec[i] = cell_stat[i].valid;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge aclk) begin
        front_reg <= front_next;
        empty_reg <= empty_next;
        full_reg  <= full_next;
        occ_reg   <= occ_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_front_data = front_reg;
    assign m_was_empty  = empty_reg;
    assign m_was_full   = full_reg;
    assign m_occupancy  = occ_reg;

    // Occupied cells form an unbroken run from the head
    `SMPQ_ASSERT(a_valid_prefix, aclk, aresetn, (valid_vec & (valid_vec + 1'b1)) == '0, "cell valid bits not contiguous from head")

    // Count agrees with the number of occupied cells
    `SMPQ_ASSERT(a_count_match, aclk, aresetn, $countones(valid_vec) == int'(count_reg), "entry count differs from occupied cells")

    // Chain stays sorted by priority, highest first
    for (genvar k = 0; k + 1 < CAPACITY; k++) begin : g_chk
        `SMPQ_ASSERT(a_sorted, aclk, aresetn, !cell_stat[k+1].valid || (cell_prio[k] >= cell_prio[k+1]), "chain out of priority order")
    end

    // A remove from a non-empty queue yields a real entry and one fewer held
    `SMPQ_ASSERT_NEXT(a_remove_result, aclk, aresetn, s_acc && (s_kind == KIND_REMOVE) && !is_empty, m_valid && !m_was_empty && (m_occupancy == $past(count_reg) - 1'b1), "remove result wrong")

endmodule

/* sv/smpq_cell.sv */
// One cell of the sorted chain: holds one entry, shifts right on insert, left on remove.
`timescale 1ns / 1ps

module smpq_cell
    import smpq_pkg::*;
#(
    parameter int DATA_BITS     = 32,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cell_op_t                 op,
    input  logic [DATA_BITS-1:0]     ins_data,
    input  logic [PRIORITY_BITS-1:0] ins_prio,
    input  cell_stat_t               left_stat,
    input  logic [DATA_BITS-1:0]     left_data,
    input  logic [PRIORITY_BITS-1:0] left_prio,
    input  logic                     right_valid,
    input  logic [DATA_BITS-1:0]     right_data,
    input  logic [PRIORITY_BITS-1:0] right_prio,
    output cell_stat_t               stat,
    output logic [DATA_BITS-1:0]     data,
    output logic [PRIORITY_BITS-1:0] prio
);

    logic                     valid_reg, valid_next;
    logic [DATA_BITS-1:0]     data_reg, data_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic                     keep;

    // Keep the entry when it ranks at or above the newcomer (stable order)
    assign keep = valid_reg && (prio_reg >= ins_prio);

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        prio_next  = prio_reg;
        case (op)
            OP_INSERT: begin
                if (!keep) begin
                    if (left_stat.keep) begin
                        // take the new entry: first slot below the kept run
                        valid_next = 1'b1;
                        data_next  = ins_data;
                        prio_next  = ins_prio;
                    end else begin
                        // shift the left neighbour's entry down
                        valid_next = left_stat.valid;
                        data_next  = left_data;
                        prio_next  = left_prio;
                    end
                end
            end
            OP_REMOVE: begin
                // advance the right neighbour's entry towards the head
                valid_next = right_valid;
                data_next  = right_data;
                prio_next  = right_prio;
            end
            default: begin
            end
        endcase
    end

    // Valid bit under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign stat.valid = valid_reg;
    assign stat.keep  = keep;
    assign data       = data_reg;
    assign prio       = prio_reg;

endmodule

/* test/tb_stable_max_priority_queue_core.sv */
// Self-checking testbench for the stable max-priority queue core.
`timescale 1ns / 1ps

module tb_stable_max_priority_queue_core;
    import smpq_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int DATA_BITS     = 32;
    localparam int PRIORITY_BITS = 8;
    localparam int OCC_BITS      = $clog2(CAPACITY + 1);
    localparam int RANDOM_ITEMS  = 1750;
    localparam int DIRECTED_ROWS = 25;
    localparam int SETTLE_CYCLES = 10;
    localparam int REPORT_LIMIT  = 10;
    localparam longint TIMEOUT_NS = 15_000_000;

    typedef struct packed {
        logic [DATA_BITS-1:0] front;
        logic                 empty;
        logic                 full;
        logic [OCC_BITS-1:0]  occ;
    } queue_result_t;

    typedef struct packed {
        logic                     fixed;
        logic                     kind;
        logic [DATA_BITS-1:0]     data;
        logic [PRIORITY_BITS-1:0] prio;
        queue_result_t            want;
    } directed_row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_kind;
    logic [DATA_BITS-1:0]     s_entry_data;
    logic [PRIORITY_BITS-1:0] s_priority_req;
    logic                     m_valid;
    logic                     m_ready;
    logic [DATA_BITS-1:0]     m_front_data;
    logic                     m_was_empty;
    logic                     m_was_full;
    logic [OCC_BITS-1:0]      m_occupancy;

    // Shadow copy of the queue, held in arrival order
    logic [DATA_BITS-1:0]     held_data [CAPACITY];
    logic [PRIORITY_BITS-1:0] held_prio [CAPACITY];
    int                       held_count;

    queue_result_t pending_results [$];
    int            mismatch_count;
    int            src_idle_pct;
    logic          cur_fixed;
    queue_result_t cur_want;

    // Directed rows: fixed expectations only where they are obvious
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1'b1, KIND_REMOVE, 32'h0000_0000, 8'h00, '{32'h0000_0000, 1'b1, 1'b0, 5'd0}},
        '{1'b1, KIND_INSERT, 32'hFFFF_FFFF, 8'h00, '{32'h0000_0000, 1'b0, 1'b0, 5'd1}},
        '{1'b1, KIND_REMOVE, 32'h1234_5678, 8'hFF, '{32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0}},
        '{1'b1, KIND_REMOVE, 32'hFFFF_FFFF, 8'hFF, '{32'h0000_0000, 1'b1, 1'b0, 5'd0}},
        '{1'b0, KIND_INSERT, 32'h0000_0000, 8'h00, '0},
        '{1'b0, KIND_INSERT, 32'hFFFF_FFFF, 8'hFF, '0},
        '{1'b0, KIND_INSERT, 32'hA5A5_0002, 8'h07, '0},
        '{1'b0, KIND_INSERT, 32'h5A5A_0003, 8'h07, '0},
        '{1'b0, KIND_INSERT, 32'h8000_0004, 8'hFF, '0},
        '{1'b0, KIND_INSERT, 32'h0000_0005, 8'h80, '0},
        '{1'b0, KIND_INSERT, 32'h7FFF_0006, 8'h07, '0},
        '{1'b0, KIND_INSERT, 32'h0001_0007, 8'h01, '0},
        '{1'b0, KIND_INSERT, 32'hDEAD_0008, 8'hFE, '0},
        '{1'b0, KIND_INSERT, 32'hBEEF_0009, 8'h7F, '0},
        '{1'b0, KIND_INSERT, 32'hC0DE_000A, 8'hFF, '0},
        '{1'b0, KIND_INSERT, 32'h0F0F_000B, 8'h00, '0},
        '{1'b0, KIND_INSERT, 32'hF0F0_000C, 8'h07, '0},
        '{1'b0, KIND_INSERT, 32'h3333_000D, 8'h55, '0},
        '{1'b0, KIND_INSERT, 32'hCCCC_000E, 8'hAA, '0},
        '{1'b0, KIND_INSERT, 32'h0000_000F, 8'h00, '0},
        '{1'b1, KIND_INSERT, 32'h9999_9999, 8'hFF, '{32'h0000_0000, 1'b0, 1'b1, 5'd16}},
        '{1'b0, KIND_REMOVE, 32'h0000_0000, 8'h00, '0},
        '{1'b0, KIND_REMOVE, 32'h0000_0000, 8'h00, '0},
        '{1'b0, KIND_REMOVE, 32'hFFFF_FFFF, 8'hFF, '0},
        '{1'b0, KIND_REMOVE, 32'h0000_0000, 8'h00, '0}
    };

    stable_max_priority_queue_core #(
        .CAPACITY      (CAPACITY),
        .DATA_BITS     (DATA_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_entry_data   (s_entry_data),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_front_data   (m_front_data),
        .m_was_empty    (m_was_empty),
        .m_was_full     (m_was_full),
        .m_occupancy    (m_occupancy)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Apply one insert or remove to the shadow queue and return its result
    function automatic queue_result_t serve_request(logic kind, logic [DATA_BITS-1:0] data,
                                                    logic [PRIORITY_BITS-1:0] prio);
        queue_result_t res;
        int            best;
        res = '0;
        if (kind == KIND_INSERT) begin
            if (held_count >= CAPACITY) begin
                res.full = 1'b1;
            end else begin
                held_data[held_count] = data;
                held_prio[held_count] = prio;
                held_count++;
            end
        end else if (held_count == 0) begin
            res.empty = 1'b1;
        end else begin
            // Strictly greater wins, so the oldest of equal priorities stays first
            best = 0;
            for (int i = 1; i < held_count; i++) begin
                if (held_prio[i] > held_prio[best])
                    best = i;
            end
            res.front = held_data[best];
            for (int i = best; i + 1 < held_count; i++) begin
                held_data[i] = held_data[i + 1];
                held_prio[i] = held_prio[i + 1];
            end
            held_count--;
        end
        res.occ = OCC_BITS'(held_count);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 2);
        else if (roll < 96)
            return $urandom_range(3, 8);
        return $urandom_range(10, 40);
    endfunction

    // Present one transaction at the falling edge and hold it until accepted
    task automatic send_item(logic kind, logic [DATA_BITS-1:0] data,
                             logic [PRIORITY_BITS-1:0] prio, logic fixed, queue_result_t want);
        int idle;
        idle = ($urandom_range(0, 99) < src_idle_pct) ? pick_gap() : 0;
        @(negedge aclk);
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        cur_fixed = fixed;
        cur_want  = want;
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_entry_data   <= data;
        s_priority_req <= prio;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Check results first, then predict for the transaction taken at this edge
    always @(posedge aclk) begin : result_check
        queue_result_t seen;
        queue_result_t want;
        queue_result_t predicted;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen = '{m_front_data, m_was_empty, m_was_full, m_occupancy};
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result front=%h empty=%b full=%b occ=%0d",
                                 $realtime, seen.front, seen.empty, seen.full, seen.occ);
                end else begin
                    want = pending_results.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"%0t: mismatch front=%h/%h empty=%b/%b full=%b/%b ",
                                      "occ=%0d/%0d (expected/actual)"}, $realtime,
                                     want.front, seen.front, want.empty, seen.empty,
                                     want.full, seen.full, want.occ, seen.occ);
                    end
                end
            end
            if (s_valid && s_ready) begin
                predicted = serve_request(s_kind, s_entry_data, s_priority_req);
                pending_results.push_back(cur_fixed ? cur_want : predicted);
            end
        end
    end

    // Result side: ready with random stalls, the stall rate changing over time
    initial begin : result_sink
        int stall_left;
        int stall_pct;
        int phase_left;
        m_ready    = 1'b0;
        stall_left = 0;
        stall_pct  = 0;
        phase_left = 0;
        forever begin
            @(negedge aclk);
            if (phase_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 30;
                    default: stall_pct = 60;
                endcase
                phase_left = $urandom_range(100, 400);
            end
            phase_left--;
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin : stimulus
        int            burst_left;
        int            insert_pct;
        int            prio_mode;
        logic          kind;
        logic [7:0]    prio;
        queue_result_t none;
        none           = '0;
        held_count     = 0;
        mismatch_count = 0;
        src_idle_pct   = 20;
        cur_fixed      = 1'b0;
        cur_want       = '0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_kind         = KIND_INSERT;
        s_entry_data   = '0;
        s_priority_req = '0;

        // Hold reset, release on a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[i])
            send_item(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].prio,
                      directed_rows[i].fixed, directed_rows[i].want);

        // Random bursts: mixes that fill, drain or churn the queue
        burst_left = 0;
        insert_pct = 50;
        prio_mode  = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
                prio_mode    = $urandom_range(0, 2);
                src_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
                burst_left   = $urandom_range(20, 80);
            end
            burst_left--;
            kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
            case (prio_mode)
                0: prio = 8'($urandom_range(0, 255));
                1: prio = 8'($urandom_range(0, 3));
                default: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
            send_item(kind, $urandom, prio, 1'b0, none);
        end

        // Drop valid and drain outstanding results
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/smpq_pkg.sv
sv/smpq_cell.sv
sv/stable_max_priority_queue_core.sv
test/tb_stable_max_priority_queue_core.sv
